/* sv/cdc_pkg.sv */
// Shared types and constants of the cloth distance constraint solver.
// Used by the top level, the square root pipeline and the divider pipeline.
// Depends on nothing.
package cdc_pkg;

  // Fixed-point format of positions, masses and lengths.
  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 30;

  // Field widths.
  localparam int POS_W   = 32;
  localparam int MASS_W  = 31;
  localparam int STIFF_W = 17;
  localparam int RANGE_W = 20;

  // Internal widths.
  localparam int MAG_W   = POS_W;
  localparam int WSUM_W  = MASS_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int RAD_W   = SQ_W + 2;
  localparam int ROOT_W  = RAD_W / 2 + 1;
  localparam int LEN_W   = ROOT_W - 1;
  localparam int TRIAL_W = RAD_W + 2;
  localparam int GPROD_W = STIFF_W + MASS_W;
  localparam int RR_W    = MASS_W + RANGE_W;
  localparam int CMP_W   = (LEN_W + FRAC_BITS > RR_W) ? LEN_W + FRAC_BITS : RR_W;
  localparam int S_CMP_W = (STIFF_W > FRAC_BITS + 1) ? STIFF_W : FRAC_BITS + 1;
  localparam int LR_W    = LEN_W;

  // Divider geometry: quotients never exceed one in Q1.30.
  localparam int DIV_N_W    = MAG_W + GAIN_BITS + 1;
  localparam int DIV_D_W    = LEN_W;
  localparam int DIV_Q_W    = GAIN_BITS + 1;
  localparam int DIV_STAGES = DIV_Q_W;
  localparam int SQRT_STAGES = ROOT_W;

  // Scaling products.
  localparam int Q_W    = LR_W + 1;
  localparam int C_W    = Q_W;
  localparam int UQ_W   = LR_W + DIV_Q_W;
  localparam int CP_W   = Q_W + DIV_Q_W;
  localparam int EXT_W  = C_W + 2;

  // Register stages: three ahead of the root, one between root and dividers,
  // three behind the dividers.
  localparam int PIPE_DEPTH = 3 + SQRT_STAGES + 1 + DIV_STAGES + 3;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int APB_W   = 32;

  typedef enum logic [1:0] {
    REG_DIST_STIFF = 2'd0,
    REG_STR_STIFF  = 2'd1,
    REG_STR_RANGE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                     command;
    logic signed [POS_W-1:0]  first_x;
    logic signed [POS_W-1:0]  first_y;
    logic signed [POS_W-1:0]  first_z;
    logic signed [POS_W-1:0]  second_x;
    logic signed [POS_W-1:0]  second_y;
    logic signed [POS_W-1:0]  second_z;
    logic [MASS_W-1:0]        first_inv_mass;
    logic [MASS_W-1:0]        second_inv_mass;
    logic [MASS_W-1:0]        rest_length;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  new_first_x;
    logic signed [POS_W-1:0]  new_first_y;
    logic signed [POS_W-1:0]  new_first_z;
    logic signed [POS_W-1:0]  new_second_x;
    logic signed [POS_W-1:0]  new_second_y;
    logic signed [POS_W-1:0]  new_second_z;
    logic                     corrected;
  } out_t;

endpackage

/* sv/cdc_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on cdc_pkg for the radicand and root widths.
module cdc_sqrt
  import cdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int Pos = ROOT_W - 1 - k;
    logic [RAD_W-1:0]   rem_in, rem_d;
    logic [ROOT_W-1:0]  root_in, root_d;
    logic [TRIAL_W-1:0] trial;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Try the next root bit: (r + 2^p)^2 - r^2 against the remainder.
    always_comb begin
      trial  = (TRIAL_W'(root_in) << (Pos + 1)) | (TRIAL_W'(1) << (2 * Pos));
      take   = TRIAL_W'(rem_in) >= trial;
      rem_d  = take ? RAD_W'(TRIAL_W'(rem_in) - trial) : rem_in;
      root_d = root_in;
      root_d[Pos] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

/* sv/cdc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on cdc_pkg for the numerator, divisor and quotient widths.
module cdc_div
  import cdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic [DIV_Q_W-1:0] quo_o
);

  logic [DIV_N_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_D_W-1:0] den_q [DIV_STAGES];
  logic [DIV_Q_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int Pos = DIV_Q_W - 1 - k;
    logic [DIV_N_W-1:0] rem_in, rem_d;
    logic [DIV_D_W-1:0] den_in;
    logic [DIV_Q_W-1:0] quo_in, quo_d;
    logic [DIV_N_W:0]   shifted;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Subtract the shifted divisor where it fits.
    always_comb begin
      shifted = (DIV_N_W + 1)'(den_in) << Pos;
      take    = {1'b0, rem_in} >= shifted;
      rem_d   = take ? DIV_N_W'({1'b0, rem_in} - shifted) : rem_in;
      quo_d   = quo_in;
      quo_d[Pos] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

/* sv/cloth_distance_constraint_solve.sv */
// Top level of the cloth distance constraint solver: APB registers and the pipeline.
// Depends on cdc_pkg, cdc_sqrt and cdc_div.
//
//   channel   direction  handshake                      word
//   in        input      in_valid_i / in_ready_o        in_t (pair, masses, rest length)
//   out       output     out_valid_o / out_ready_i      out_t (corrected pair, flag)
//   config    input      psel, penable, pwrite, pready  32-bit register write/read
//
// One word enters per cycle while the output is not stalled, and a new word can enter before the last has left.
// Most of the pipeline depth lies in the 34-stage root pipeline and the 31-stage dividers.
// Reset clears the valid bits and sets all three registers to 1.0.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module cloth_distance_constraint_solve
  import cdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  typedef logic [2:0][POS_W-1:0] vec_t;

  typedef struct packed {
    logic                     cmd;
    vec_t                     p0;
    vec_t                     p1;
    logic [2:0]               dneg;
    logic [2:0][MAG_W-1:0]    mag;
    logic [MASS_W-1:0]        w0;
    logic [MASS_W-1:0]        w1;
    logic [WSUM_W-1:0]        wsum;
    logic [MASS_W-1:0]        rest;
  } s1_t;

  typedef struct packed {
    s1_t                      base;
    logic [GPROD_W-1:0]       prod0;
    logic [GPROD_W-1:0]       prod1;
    logic [RR_W-1:0]          rr;
  } side_t;

  typedef struct packed {
    vec_t                     p0;
    vec_t                     p1;
    logic [2:0]               dneg;
    logic                     apply;
    logic                     neg_lr;
    logic [LR_W-1:0]          lr;
  } corr_t;

  typedef struct packed {
    corr_t                    side;
    logic [2:0][Q_W-1:0]      q;
    logic [DIV_Q_W-1:0]       g0;
    logic [DIV_Q_W-1:0]       g1;
  } f_t;

  typedef struct packed {
    corr_t                    side;
    logic [2:0][C_W-1:0]      c0;
    logic [2:0][C_W-1:0]      c1;
  } g_t;

  localparam logic [S_CMP_W-1:0] S_ONE = S_CMP_W'(1) << FRAC_BITS;
  localparam logic [UQ_W-1:0]    HALF_U = UQ_W'(1) << (GAIN_BITS - 1);
  localparam logic [CP_W-1:0]    HALF_C = CP_W'(1) << (GAIN_BITS - 1);

  function automatic logic [POS_W-1:0] sat_pos(input logic [EXT_W-1:0] v);
    logic [EXT_W-POS_W:0] upper;
    upper = v[EXT_W-1:POS_W-1];
    if (upper == '0 || upper == '1) begin
      return v[POS_W-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [STIFF_W-1:0] dist_stiff_q, str_stiff_q;
  logic [RANGE_W-1:0] str_range_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_stiff_q <= STIFF_W'(1) << FRAC_BITS;
      str_stiff_q  <= STIFF_W'(1) << FRAC_BITS;
      str_range_q  <= RANGE_W'(1) << FRAC_BITS;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DIST_STIFF: dist_stiff_q <= pwdata[STIFF_W-1:0];
        REG_STR_STIFF:  str_stiff_q  <= pwdata[STIFF_W-1:0];
        REG_STR_RANGE:  str_range_q  <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (cfg_sel)
      REG_DIST_STIFF: prdata = APB_W'(dist_stiff_q);
      REG_STR_STIFF:  prdata = APB_W'(str_stiff_q);
      REG_STR_RANGE:  prdata = APB_W'(str_range_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one enable for every stage, valid bits shift alongside.
  logic                  en;
  logic [PIPE_DEPTH-1:0] valid_q;

  assign en          = !valid_q[PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: difference vector and its magnitude, mass sum.
  s1_t              s1_d, s1_q;
  logic [POS_W:0]   diff [3];

  always_comb begin
    s1_d.cmd   = in_data_i.command;
    s1_d.p0[0] = in_data_i.first_x;
    s1_d.p0[1] = in_data_i.first_y;
    s1_d.p0[2] = in_data_i.first_z;
    s1_d.p1[0] = in_data_i.second_x;
    s1_d.p1[1] = in_data_i.second_y;
    s1_d.p1[2] = in_data_i.second_z;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {s1_d.p1[i][POS_W-1], s1_d.p1[i]} - {s1_d.p0[i][POS_W-1], s1_d.p0[i]};
      s1_d.dneg[i] = diff[i][POS_W];
      s1_d.mag[i]  = s1_d.dneg[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
    end
    s1_d.w0   = in_data_i.first_inv_mass;
    s1_d.w1   = in_data_i.second_inv_mass;
    s1_d.wsum = WSUM_W'(in_data_i.first_inv_mass) + WSUM_W'(in_data_i.second_inv_mass);
    s1_d.rest = in_data_i.rest_length;
  end

  always_ff @(posedge clk_i) begin
    if (en) s1_q <= s1_d;
  end

  // Stage 2: squares, stiffness times mass, rest length times range.
  logic [STIFF_W-1:0]     s_raw, s_clamp;
  logic [2:0][SQ_W-1:0]   sq_d, sq_q;
  side_t                  s2_d, s2_q;

  always_comb begin
    s_raw   = s1_q.cmd ? str_stiff_q : dist_stiff_q;
    s_clamp = (S_CMP_W'(s_raw) > S_ONE) ? STIFF_W'(S_ONE) : s_raw;
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = SQ_W'(s1_q.mag[i]) * SQ_W'(s1_q.mag[i]);
    end
    s2_d.base  = s1_q;
    s2_d.prod0 = GPROD_W'(s_clamp) * GPROD_W'(s1_q.w0);
    s2_d.prod1 = GPROD_W'(s_clamp) * GPROD_W'(s1_q.w1);
    s2_d.rr    = RR_W'(s1_q.rest) * RR_W'(str_range_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= sq_d;
      s2_q <= s2_d;
    end
  end

  // Stage 3: sum of squares.
  logic [RAD_W-1:0] rad_q;
  side_t            s3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
      s3_q  <= s2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Length of the pair, with the side data delayed to match.
  logic [ROOT_W-1:0] root;
  side_t             sqd_q [SQRT_STAGES];

  cdc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqd_q[0] <= s3_q;
      for (int k = 1; k < SQRT_STAGES; k++) sqd_q[k] <= sqd_q[k-1];
    end
  end

  // Stage E: decision, length error and divider operands.
  side_t               se;
  logic [LEN_W-1:0]    len, rest_ext;
  logic                stretch_ok;
  corr_t               e_d, e_q;
  logic [DIV_N_W-1:0]  un_d [3];
  logic [DIV_N_W-1:0]  un_q [3];
  logic [DIV_N_W-1:0]  gn_d [2];
  logic [DIV_N_W-1:0]  gn_q [2];
  logic [DIV_D_W-1:0]  len_q, wden_q;

  always_comb begin
    se         = sqd_q[SQRT_STAGES-1];
    len        = root[LEN_W-1:0];
    rest_ext   = LEN_W'(se.base.rest);
    stretch_ok = (CMP_W'(len) << FRAC_BITS) < CMP_W'(se.rr);
    e_d.p0     = se.base.p0;
    e_d.p1     = se.base.p1;
    e_d.dneg   = se.base.dneg;
    e_d.apply  = (len != '0) && (se.base.wsum != '0) &&
                 (se.base.cmd ? stretch_ok : (len != rest_ext));
    e_d.neg_lr = len < rest_ext;
    e_d.lr     = e_d.neg_lr ? rest_ext - len : len - rest_ext;
    for (int i = 0; i < 3; i++) begin
      un_d[i] = (DIV_N_W'(se.base.mag[i]) << GAIN_BITS) + DIV_N_W'(len >> 1);
    end
    gn_d[0] = (DIV_N_W'(se.prod0) << (GAIN_BITS - FRAC_BITS)) +
              DIV_N_W'(se.base.wsum >> 1);
    gn_d[1] = (DIV_N_W'(se.prod1) << (GAIN_BITS - FRAC_BITS)) +
              DIV_N_W'(se.base.wsum >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q    <= e_d;
      un_q   <= un_d;
      gn_q   <= gn_d;
      len_q  <= len;
      wden_q <= DIV_D_W'(se.base.wsum);
    end
  end

  // ---------------------------------------------------------------------------
  // Unit direction per axis and the mass shares, all in Q1.30.
  logic [DIV_Q_W-1:0] u_quo [3];
  logic [DIV_Q_W-1:0] g_quo [2];
  corr_t              dvd_q [DIV_STAGES];

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    cdc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (un_q[i]),
      .den_i (len_q),
      .quo_o (u_quo[i])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_gdiv
    cdc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (gn_q[j]),
      .den_i (wden_q),
      .quo_o (g_quo[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd_q[0] <= e_q;
      for (int k = 1; k < DIV_STAGES; k++) dvd_q[k] <= dvd_q[k-1];
    end
  end

  // Stage F: length error along each axis.
  f_t              f_d, f_q;
  logic [UQ_W-1:0] uprod [3];

  always_comb begin
    f_d.side = dvd_q[DIV_STAGES-1];
    f_d.g0   = g_quo[0];
    f_d.g1   = g_quo[1];
    for (int i = 0; i < 3; i++) begin
      uprod[i]  = UQ_W'(f_d.side.lr) * UQ_W'(u_quo[i]);
      f_d.q[i]  = Q_W'((uprod[i] + HALF_U) >> GAIN_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) f_q <= f_d;
  end

  // Stage G: per-particle corrections.
  g_t              g_d, g_q;
  logic [CP_W-1:0] cprod0 [3];
  logic [CP_W-1:0] cprod1 [3];

  always_comb begin
    g_d.side = f_q.side;
    for (int i = 0; i < 3; i++) begin
      cprod0[i] = CP_W'(f_q.q[i]) * CP_W'(f_q.g0);
      cprod1[i] = CP_W'(f_q.q[i]) * CP_W'(f_q.g1);
      g_d.c0[i] = C_W'((cprod0[i] + HALF_C) >> GAIN_BITS);
      g_d.c1[i] = C_W'((cprod1[i] + HALF_C) >> GAIN_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) g_q <= g_d;
  end

  // Stage H: apply the signed corrections and saturate into the output word, or pass uncorrected pairs through.
  logic [EXT_W-1:0] pe0 [3];
  logic [EXT_W-1:0] pe1 [3];
  logic [EXT_W-1:0] ce0 [3];
  logic [EXT_W-1:0] ce1 [3];
  logic [EXT_W-1:0] n0 [3];
  logic [EXT_W-1:0] n1 [3];
  logic [2:0]       flip;
  vec_t             r0, r1;
  out_t             out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      flip[i] = g_q.side.neg_lr != g_q.side.dneg[i];
      pe0[i]  = {{(EXT_W-POS_W){g_q.side.p0[i][POS_W-1]}}, g_q.side.p0[i]};
      pe1[i]  = {{(EXT_W-POS_W){g_q.side.p1[i][POS_W-1]}}, g_q.side.p1[i]};
      ce0[i]  = EXT_W'(g_q.c0[i]);
      ce1[i]  = EXT_W'(g_q.c1[i]);
      n0[i]   = flip[i] ? pe0[i] - ce0[i] : pe0[i] + ce0[i];
      n1[i]   = flip[i] ? pe1[i] + ce1[i] : pe1[i] - ce1[i];
      r0[i]   = g_q.side.apply ? sat_pos(n0[i]) : g_q.side.p0[i];
      r1[i]   = g_q.side.apply ? sat_pos(n1[i]) : g_q.side.p1[i];
    end
    out_d.new_first_x  = r0[0];
    out_d.new_first_y  = r0[1];
    out_d.new_first_z  = r0[2];
    out_d.new_second_x = r1[0];
    out_d.new_second_y = r1[1];
    out_d.new_second_z = r1[2];
    out_d.corrected    = g_q.side.apply;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A stall must freeze the occupancy of every stage.
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("pipeline occupancy changed during a stall");

  // A pair that is not corrected leaves unflagged, with its first x and second z positions untouched.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && valid_q[PIPE_DEPTH-2] && !g_q.side.apply |=>
      out_data_o.new_first_x == $past(g_q.side.p0[0]) &&
      out_data_o.new_second_z == $past(g_q.side.p1[2]) && !out_data_o.corrected)
    else $error("uncorrected pair did not pass through");

  // A new output word only appears when the stage before the output advanced a valid word.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[PIPE_DEPTH-2] && en))
    else $error("output valid without a word behind it");
`endif

endmodule
